/* rtl/core/hpm_pkg.sv */
// Package: shared types and constants of the half precision multiplier.
package hpm_pkg;

  localparam int unsigned HalfW  = 16;
  localparam int unsigned SigW   = 11;
  localparam int unsigned ProdW  = 2 * SigW;
  localparam int unsigned LeadW  = 5;

  localparam logic [15:0] ExpField = 16'h7c00;
  localparam logic [15:0] NegMax   = 16'hfbff;
  localparam logic [10:0] Hidden   = 11'h400;
  localparam logic [4:0]  ExpMax   = 5'd31;
  localparam logic [5:0]  Bias     = 6'd15;
  localparam logic signed [5:0] MinExp = -6'sd14;

  // Stage 1 result: decoded operands and significand product.
  typedef struct packed {
    logic              valid;
    logic              special;
    logic [15:0]       spec_res;
    logic              inv;
    logic              sign;
    logic [ProdW-1:0]  prod;
    logic signed [6:0] esum;
  } hpm_s1_t;

  // Stage 2 result: quantum exponent field and alignment shift.
  typedef struct packed {
    logic              valid;
    logic              special;
    logic [15:0]       spec_res;
    logic              inv;
    logic              sign;
    logic [ProdW-1:0]  prod;
    logic [5:0]        qe;
    logic signed [6:0] shamt;
  } hpm_s2_t;

endpackage

/* rtl/core/hpm_if.sv */
// Interfaces: operand and result channels of the half precision multiplier.
interface hpm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  modport source (output valid, operand_a, operand_b, input ready);
  modport sink   (input valid, operand_a, operand_b, output ready);
endinterface

interface hpm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] product;
  logic        invalid;
  logic        inexact;
  logic        rounded_up;
  modport source (output valid, product, invalid, inexact, rounded_up, input ready);
  modport sink   (input valid, product, invalid, inexact, rounded_up, output ready);
endinterface

/* rtl/core/half_precision_multiplier.sv */
// Top level: binary16 multiplier, round toward positive infinity.
//
// in_ch carries operand_a and operand_b (raw binary16 patterns); out_ch
// carries product, invalid, inexact and rounded_up. Both use valid/ready;
// an item moves at a clock edge where both are high.
// Pipeline: three register stages (decode and multiply, leading-one search,
// align and round). An accepted item passes through s1, s2 and the result
// register and then shows on out_ch until it is taken. Throughput is one
// item per cycle while out_ch.ready is high; the 11x11 significand
// multiply and the 22-bit leading-one search set the stage depth.
// All stages advance together whenever the result register is empty or
// being taken, so in_ch.ready follows out_ch.ready while the result
// register is full. During a stall every stage holds; nothing is lost or
// repeated. Up to three items can be in flight.
// Reset (rst_n low, synchronous) clears all valid bits; the block takes
// items as soon as reset is released.
module half_precision_multiplier import hpm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  hpm_in_if.sink  in_ch,
  hpm_out_if.source out_ch
);
  logic    en;
  hpm_s1_t s1;
  hpm_s2_t s2;

  // Move the whole pipeline when the output slot frees.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  hpm_unpack u_unpack (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
    .a(in_ch.operand_a), .b(in_ch.operand_b), .s1_r(s1)
  );

  hpm_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .s1(s1), .s2_r(s2)
  );

  hpm_round u_round (
    .clk(clk), .rst_n(rst_n), .en(en), .s2(s2),
    .valid_r(out_ch.valid), .product_r(out_ch.product),
    .invalid_r(out_ch.invalid), .inexact_r(out_ch.inexact),
    .rounded_up_r(out_ch.rounded_up)
  );
endmodule

/* rtl/core/hpm_unpack.sv */
// Stage 1: decode operands, classify special cases, multiply significands.
module hpm_unpack import hpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output hpm_s1_t     s1_r
);
  logic [4:0]  ea_f, eb_f;
  logic [9:0]  fa, fb;
  logic        za, zb, ia, ib, na, nb;
  logic [10:0] sa, sb;
  logic signed [5:0] ea, eb;
  hpm_s1_t     s1_nxt;

  always_comb begin
    ea_f = a[14:10];
    eb_f = b[14:10];
    fa   = a[9:0];
    fb   = b[9:0];
    za = (ea_f == 5'd0) && (fa == 10'd0);
    zb = (eb_f == 5'd0) && (fb == 10'd0);
    ia = (ea_f == ExpMax) && (fa == 10'd0);
    ib = (eb_f == ExpMax) && (fb == 10'd0);
    na = (ea_f == ExpMax) && (fa != 10'd0);
    nb = (eb_f == ExpMax) && (fb != 10'd0);
    sa = (ea_f == 5'd0) ? {1'b0, fa} : (Hidden | {1'b0, fa});
    sb = (eb_f == 5'd0) ? {1'b0, fb} : (Hidden | {1'b0, fb});
    ea = (ea_f == 5'd0) ? MinExp : $signed({1'b0, ea_f} - Bias);
    eb = (eb_f == 5'd0) ? MinExp : $signed({1'b0, eb_f} - Bias);

    s1_nxt.valid = in_valid;
    s1_nxt.sign  = a[15] ^ b[15];
    s1_nxt.inv   = na || nb || (za && ib) || (ia && zb);
    s1_nxt.special = s1_nxt.inv || ia || ib || za || zb;
    // Priority: invalid, infinity, zero.
    priority if (s1_nxt.inv) begin
      s1_nxt.spec_res = 16'h0000;
    end else if (ia || ib) begin
      s1_nxt.spec_res = {s1_nxt.sign, 15'd0} | ExpField;
    end else begin
      s1_nxt.spec_res = {s1_nxt.sign, 15'd0};
    end
    s1_nxt.prod = ProdW'(sa) * ProdW'(sb);
    s1_nxt.esum = 7'(ea) + 7'(eb);
  end

  // Advance stage when the pipeline moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (en) begin
      s1_r.valid <= s1_nxt.valid;
    end
    if (en) begin
      s1_r.special  <= s1_nxt.special;
      s1_r.spec_res <= s1_nxt.spec_res;
      s1_r.inv      <= s1_nxt.inv;
      s1_r.sign     <= s1_nxt.sign;
      s1_r.prod     <= s1_nxt.prod;
      s1_r.esum     <= s1_nxt.esum;
    end
  end
endmodule

/* rtl/core/hpm_norm.sv */
// Stage 2: find leading one, choose result quantum and alignment shift.
module hpm_norm import hpm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  hpm_s1_t s1,
  output hpm_s2_t s2_r
);
  logic [LeadW-1:0]  lead;
  logic signed [7:0] e_w;
  logic              tiny;
  hpm_s2_t           s2_nxt;

  always_comb begin
    lead = '0;
    for (int i = 0; i < ProdW; i++) begin
      if (s1.prod[i]) lead = LeadW'(i);
    end
    e_w  = 8'(s1.esum) - 8'sd20 + $signed({3'b000, lead});
    tiny = e_w < -8'sd14;

    s2_nxt.valid    = s1.valid;
    s2_nxt.special  = s1.special;
    s2_nxt.spec_res = s1.spec_res;
    s2_nxt.inv      = s1.inv;
    s2_nxt.sign     = s1.sign;
    s2_nxt.prod     = s1.prod;
    s2_nxt.qe       = tiny ? 6'd0 : 6'(e_w + 8'sd14);
    s2_nxt.shamt    = tiny ? (-7'sd4 - s1.esum) : ($signed({2'b00, lead}) - 7'sd10);
  end

  // Advance stage when the pipeline moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en) begin
      s2_r.valid <= s2_nxt.valid;
    end
    if (en) begin
      s2_r.special  <= s2_nxt.special;
      s2_r.spec_res <= s2_nxt.spec_res;
      s2_r.inv      <= s2_nxt.inv;
      s2_r.sign     <= s2_nxt.sign;
      s2_r.prod     <= s2_nxt.prod;
      s2_r.qe       <= s2_nxt.qe;
      s2_r.shamt    <= s2_nxt.shamt;
    end
  end
endmodule

/* rtl/core/hpm_round.sv */
// Stage 3: align product, round toward positive, pack result register.
module hpm_round import hpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  hpm_s2_t     s2,
  output logic        valid_r,
  output logic [15:0] product_r,
  output logic        invalid_r,
  output logic        inexact_r,
  output logic        rounded_up_r
);
  logic [ProdW:0]  mask;
  logic [ProdW:0]  rsh;
  logic [11:0]     kept, kept_up;
  logic            rem;
  logic            up;
  logic [16:0]     bits;
  logic            ovf;
  logic [15:0]     product_nxt;
  logic            inexact_nxt, rounded_up_nxt;

  always_comb begin
    mask = ({{ProdW{1'b0}}, 1'b1} << s2.shamt[4:0]) - 1'b1;
    rsh  = {1'b0, s2.prod} >> s2.shamt[4:0];
    if (s2.shamt < 0) begin
      kept = 12'(s2.prod << 4'(-s2.shamt));
      rem  = 1'b0;
    end else begin
      kept = 12'(rsh);
      rem  = |(s2.prod & mask[ProdW-1:0]);
    end
    up      = rem && !s2.sign;
    kept_up = kept + 12'(up);
    bits    = {1'b0, s2.qe, 10'd0} + 17'(kept_up);
    ovf     = bits >= 17'(ExpField);

    // Special results bypass rounding.
    if (s2.special) begin
      product_nxt    = s2.spec_res;
      inexact_nxt    = 1'b0;
      rounded_up_nxt = 1'b0;
    end else if (ovf) begin
      product_nxt    = s2.sign ? NegMax : ExpField;
      inexact_nxt    = 1'b1;
      rounded_up_nxt = !s2.sign;
    end else begin
      product_nxt    = {s2.sign, bits[14:0]};
      inexact_nxt    = rem;
      rounded_up_nxt = up;
    end
  end

  // Hold result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= s2.valid;
    end
    if (en) begin
      product_r    <= product_nxt;
      invalid_r    <= s2.inv;
      inexact_r    <= inexact_nxt;
      rounded_up_r <= rounded_up_nxt;
    end
  end
endmodule

/* rtl/core/hpm_checker.sv */
// Checker: port-level properties of the half precision multiplier.
module hpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] product,
  input logic        invalid,
  input logic        inexact,
  input logic        rounded_up
);
  // Invalid items give zero and no rounding flags.
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && invalid |-> product == 16'h0000 && !inexact && !rounded_up)
    else $error("invalid result not clean");

  // Rounding up only for inexact positive results.
  a_up_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rounded_up |-> inexact && !product[15])
    else $error("rounded_up without positive inexact result");

  // Negative inexact results never exceed the largest finite magnitude.
  a_neg_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inexact && product[15] |-> product[14:10] != 5'd31)
    else $error("negative inexact result reached infinity");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(product) && $stable(invalid)
      && $stable(inexact) && $stable(rounded_up))
    else $error("stalled result changed");
endmodule

bind half_precision_multiplier hpm_checker u_hpm_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .product(out_ch.product), .invalid(out_ch.invalid), .inexact(out_ch.inexact),
  .rounded_up(out_ch.rounded_up)
);

/* sim/hpm_tb_if.sv */
// Testbench package: operand pair and result item types.
`timescale 1ns / 100ps
package hpm_tb_pkg;
  // One operand pair and one expected or observed result.
  typedef struct packed {
    logic [15:0] operand_a;
    logic [15:0] operand_b;
  } hpm_pair_t;

  typedef struct packed {
    logic [15:0] product;
    logic        invalid;
    logic        inexact;
    logic        rounded_up;
  } hpm_res_t;
endpackage

/* sim/half_precision_multiplier_tb.sv */
// Testbench: random and directed binary16 products checked against a rounding predictor.
`timescale 1ns / 100ps
module half_precision_multiplier_tb;
  import hpm_pkg::*;
  import hpm_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches = 0;
  bit   stim_done = 1'b0;
  int   hold_cycles = 0;

  hpm_pair_t pending_pairs[$];
  hpm_res_t  expected_products[$];

  hpm_in_if  in_ch ();
  hpm_out_if out_ch ();

  half_precision_multiplier dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  // Predict the rounded-up binary16 product of one operand pair.
  function automatic hpm_res_t predict_product(logic [15:0] a, logic [15:0] b);
    hpm_res_t r;
    logic [10:0] sig_a, sig_b;
    int exp_a, exp_b, base, lead, e, qexp, sh;
    logic [21:0] prod;
    logic [31:0] kept, rem, bits;
    logic sign;
    bit zero_a, zero_b, inf_a, inf_b, nan_a, nan_b;
    r = '0;
    sign = a[15] ^ b[15];
    nan_a = (a[14:10] == 5'd31) && (a[9:0] != 0);
    nan_b = (b[14:10] == 5'd31) && (b[9:0] != 0);
    inf_a = (a[14:10] == 5'd31) && (a[9:0] == 0);
    inf_b = (b[14:10] == 5'd31) && (b[9:0] == 0);
    zero_a = (a[14:0] == 0);
    zero_b = (b[14:0] == 0);
    if (nan_a || nan_b || (zero_a && inf_b) || (inf_a && zero_b)) begin
      r.invalid = 1'b1;
      return r;
    end
    if (inf_a || inf_b) begin
      r.product = {sign, 15'h7c00};
      return r;
    end
    if (zero_a || zero_b) begin
      r.product = {sign, 15'h0};
      return r;
    end
    sig_a = (a[14:10] == 0) ? {1'b0, a[9:0]} : {1'b1, a[9:0]};
    sig_b = (b[14:10] == 0) ? {1'b0, b[9:0]} : {1'b1, b[9:0]};
    exp_a = (a[14:10] == 0) ? -14 : int'(a[14:10]) - 15;
    exp_b = (b[14:10] == 0) ? -14 : int'(b[14:10]) - 15;
    prod = sig_a * sig_b;
    base = exp_a + exp_b - 20;
    lead = 0;
    for (int i = 0; i < 22; i++) if (prod[i]) lead = i;
    e = base + lead;
    qexp = ((e < -14) ? -14 : e) - 10;
    sh = qexp - base;
    if (sh <= 0) begin
      kept = 32'(prod) << (-sh);
      rem = 0;
    end else if (sh >= 32) begin
      kept = 0;
      rem = 32'(prod);
    end else begin
      kept = 32'(prod) >> sh;
      rem = 32'(prod) & ((32'd1 << sh) - 1);
    end
    if (rem != 0) begin
      r.inexact = 1'b1;
      if (!sign) begin
        kept++;
        r.rounded_up = 1'b1;
      end
    end
    bits = (32'(qexp + 24) << 10) + kept;
    if (bits >= 32'h7c00) begin
      r.inexact = 1'b1;
      r.rounded_up = !sign;
      r.product = sign ? NegMax : ExpField;
    end else begin
      r.product = {sign, bits[14:0]};
    end
    return r;
  endfunction

  // Draw an operand biased toward special classes.
  function automatic logic [15:0] draw_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0: v[14:10] = 5'd0;
      1: v[14:0] = 15'h0;
      2: v[14:10] = 5'd31;
      3: v[14:10] = 5'($urandom_range(1, 6));
      4: v[14:10] = 5'($urandom_range(24, 30));
      default: ;
    endcase
    return v;
  endfunction

  // Drive operand pairs with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.operand_a <= '0;
      in_ch.operand_b <= '0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the offered item
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_pairs.size() > 0) begin
      hpm_pair_t p;
      p = pending_pairs.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.operand_a <= p.operand_a;
      in_ch.operand_b <= p.operand_b;
      expected_products.push_back(predict_product(p.operand_a, p.operand_b));
      send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Count down the long receiver hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0)
      hold_cycles <= hold_cycles - 1;
  end

  // Stall the result side at random, with one long hold-off.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready)
        recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      hpm_res_t got, want;
      got = {out_ch.product, out_ch.invalid, out_ch.inexact, out_ch.rounded_up};
      if (expected_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_products.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: product %h/%h invalid %b/%b inexact %b/%b up %b/%b",
                     want.product, got.product, want.invalid, got.invalid,
                     want.inexact, got.inexact, want.rounded_up, got.rounded_up);
        end
      end
    end
  end

  // Fill the item queue, reset, then wait for the drain.
  initial begin
    logic [15:0] edge_vals[12];
    edge_vals = '{16'h0000, 16'h8000, 16'h7c00, 16'hfc00, 16'h7e00, 16'h7c01,
                  16'h0001, 16'h83ff, 16'h7bff, 16'hfbff, 16'h3c00, 16'h0400};
    in_ch.valid = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 12; i++)
      pending_pairs.push_back('{edge_vals[i], edge_vals[(i * 5 + 3) % 12]});
    pending_pairs.push_back('{16'h7bff, 16'h3c01});
    pending_pairs.push_back('{16'hfbff, 16'h3c01});
    pending_pairs.push_back('{16'h0001, 16'h3800});
    pending_pairs.push_back('{16'h03ff, 16'h3c01});
    pending_pairs.push_back('{16'h8001, 16'h3400});
    pending_pairs.push_back('{16'hffff, 16'hffff});
    for (int i = 0; i < 900; i++)
      pending_pairs.push_back('{draw_operand(), draw_operand()});
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (50) @(posedge clk);
    hold_cycles <= 40;
    wait (pending_pairs.size() == 0);
    while (in_ch.valid) @(posedge clk);
    while (expected_products.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Bound the run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
